// ===== hdl/urx_pkg.sv =====
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants of the oversampled uart receiver.
// ----------------------------------------------------------------------------
package urx_pkg;

  localparam int DATA_W     = 8;
  localparam int WAIT_W     = 17;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 17;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_RX_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT = CFG_IDX_W'(1);

  localparam logic [WAIT_W-1:0] RESET_TIMEOUT = WAIT_W'(100000);
  localparam int                SAMPLE_PHASE  = 2;

  typedef struct packed {
    logic              rx_enable;
    logic [WAIT_W-1:0] timeout_limit;
  } cfg_t;

  typedef struct packed {
    logic              byte_done;
    logic [DATA_W-1:0] rx_data;
    logic              frame_dropped;
    logic              timed_out;
  } res_t;

endpackage

// ===== hdl/urx_in_if.sv =====
// ----------------------------------------------------------------------------
// urx_in_if
// Tick channel: one sampled line level per transaction.
// ----------------------------------------------------------------------------
interface urx_in_if;
  logic valid;
  logic ready;
  logic line_level;
  logic rearm;

  modport source (output valid, output line_level, output rearm, input ready);
  modport sink (input valid, input line_level, input rearm, output ready);
endinterface

// ===== hdl/urx_out_if.sv =====
// ----------------------------------------------------------------------------
// urx_out_if
// Result channel: one receiver status per tick.
// ----------------------------------------------------------------------------
interface urx_out_if;
  logic                      valid;
  logic                      ready;
  logic                      byte_done;
  logic [urx_pkg::DATA_W-1:0] rx_data;
  logic                      frame_dropped;
  logic                      timed_out;

  modport source (output valid, output byte_done, output rx_data,
                  output frame_dropped, output timed_out, input ready);
  modport sink (input valid, input byte_done, input rx_data,
                input frame_dropped, input timed_out, output ready);
endinterface

// ===== hdl/urx_cfg_if.sv =====
// ----------------------------------------------------------------------------
// urx_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface urx_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [urx_pkg::CFG_IDX_W-1:0]  index;
  logic [urx_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/uart_rx_oversampled.sv =====
// ----------------------------------------------------------------------------
// uart_rx_oversampled
// Oversampled 8N1 uart receiver, one line sample per input transaction.
// ----------------------------------------------------------------------------
// in_ch carries one oversampling tick (line_level, rearm); OVERSAMPLE ticks
// make one bit period. out_ch returns one status per tick: byte_done,
// rx_data (byte register after the tick), frame_dropped and timed_out.
// cfg_ch writes rx_enable (index 0) and timeout_limit (index 1); it is
// always ready and should only be used while no tick is in flight.
// A tick accepted on in_ch is captured in the input register, processed by
// the receiver state update, and its status is captured in the output
// register, which drives out_ch.valid. Throughput: one tick per cycle while
// out_ch is not stalled, as the state update is combinational.
// When out_ch stalls, the output register holds its status and the input
// register still takes one more tick; in_ch.ready then drops until the
// result is taken. Reset (rst_n low, synchronous) empties both registers,
// clears the receiver state and restores rx_enable = 1 and
// timeout_limit = 100000.
// ----------------------------------------------------------------------------
module uart_rx_oversampled #(
  parameter int OVERSAMPLE = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  urx_in_if.sink    in_ch,
  urx_out_if.source out_ch,
  urx_cfg_if.sink   cfg_ch
);
  import urx_pkg::*;

  logic in_v_r, in_v_nxt;
  logic line_r, rearm_r;
  logic out_v_r, out_v_nxt;
  res_t res_r;
  res_t res;
  cfg_t cfg;
  logic advance;
  logic in_take;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign in_v_nxt    = in_take ? 1'b1 : (advance ? 1'b0 : in_v_r);
  assign out_v_nxt   = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  urx_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  urx_core #(
    .OVERSAMPLE (OVERSAMPLE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (advance),
    .line_level (line_r),
    .rearm      (rearm_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      line_r  <= in_ch.line_level;
      rearm_r <= in_ch.rearm;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.byte_done     = res_r.byte_done;
  assign out_ch.rx_data       = res_r.rx_data;
  assign out_ch.frame_dropped = res_r.frame_dropped;
  assign out_ch.timed_out     = res_r.timed_out;

endmodule

// ===== hdl/urx_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// urx_cfg_regs
// Configuration registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module urx_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  urx_cfg_if.sink        cfg_ch,
  output urx_pkg::cfg_t  cfg
);
  import urx_pkg::*;

  logic              rx_enable_r, rx_enable_nxt;
  logic [WAIT_W-1:0] timeout_limit_r, timeout_limit_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    rx_enable_nxt     = rx_enable_r;
    timeout_limit_nxt = timeout_limit_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_RX_ENABLE:     rx_enable_nxt     = cfg_ch.data[0];
        REG_TIMEOUT_LIMIT: timeout_limit_nxt = cfg_ch.data[WAIT_W-1:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_enable_r     <= 1'b1;
      timeout_limit_r <= RESET_TIMEOUT;
    end else begin
      rx_enable_r     <= rx_enable_nxt;
      timeout_limit_r <= timeout_limit_nxt;
    end
  end

  assign cfg.rx_enable     = rx_enable_r;
  assign cfg.timeout_limit = timeout_limit_r;

endmodule

// ===== hdl/urx_core.sv =====
// ----------------------------------------------------------------------------
// urx_core
// Receiver state and the per-tick update: start detection, bit sampling,
// stop check and wait timeout.
// ----------------------------------------------------------------------------
module urx_core #(
  parameter int OVERSAMPLE = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  logic          line_level,
  input  logic          rearm,
  input  urx_pkg::cfg_t cfg,
  output urx_pkg::res_t res
);
  import urx_pkg::*;

  localparam int PHASE_W = $clog2(10 * OVERSAMPLE);
  localparam int SUB_W   = $clog2(OVERSAMPLE);
  localparam int QUO_W   = 4;

  localparam logic [PHASE_W-1:0] DATA_START = PHASE_W'(OVERSAMPLE);
  localparam logic [PHASE_W-1:0] STOP_START = PHASE_W'(9 * OVERSAMPLE);
  localparam logic [PHASE_W-1:0] DROP_AFTER = PHASE_W'(9 * OVERSAMPLE + OVERSAMPLE / 2);
  localparam logic [PHASE_W-1:0] FRAME_LAST = PHASE_W'(10 * OVERSAMPLE - 1);
  localparam logic [SUB_W-1:0]   SUB_LAST   = SUB_W'(OVERSAMPLE - 1);
  localparam logic [SUB_W-1:0]   SUB_SAMPLE = SUB_W'(SAMPLE_PHASE);

  // sub_r tracks phase mod OVERSAMPLE, quo_r tracks phase / OVERSAMPLE
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]  shift_r, shift_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic               adv, clr;
  logic               done, dropped, tout;
  logic [2:0]         bit_idx;

  assign bit_idx = 3'(quo_r - QUO_W'(1));

  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    quo_nxt   = quo_r;
    shift_nxt = shift_r;
    wait_nxt  = wait_r;
    adv       = 1'b0;
    clr       = 1'b0;
    done      = 1'b0;
    dropped   = 1'b0;
    tout      = 1'b0;

    if (rearm) begin
      clr = 1'b1;
    end else if (cfg.rx_enable) begin
      if (wait_r == cfg.timeout_limit) begin
        clr      = 1'b1;
        wait_nxt = '0;
        tout     = 1'b1;
      end else if (phase_r == '0) begin
        if (line_level) adv = 1'b1;
        else            wait_nxt = wait_r + WAIT_W'(1);
      end else if (phase_r <= DATA_START) begin
        if (!line_level) begin
          shift_nxt = '0;
          adv       = 1'b1;
          wait_nxt  = '0;
        end else begin
          wait_nxt = wait_r + WAIT_W'(1);
        end
      end else begin
        if (phase_r <= STOP_START && sub_r == SUB_SAMPLE && line_level)
          shift_nxt[bit_idx] = 1'b1;
        if (phase_r > DROP_AFTER && !line_level) begin
          clr      = 1'b1;
          wait_nxt = '0;
          dropped  = 1'b1;
        end else if (phase_r == FRAME_LAST) begin
          clr      = 1'b1;
          wait_nxt = '0;
          done     = 1'b1;
        end else begin
          adv = 1'b1;
        end
      end
    end

    if (clr) begin
      phase_nxt = '0;
      sub_nxt   = '0;
      quo_nxt   = '0;
    end else if (adv) begin
      phase_nxt = phase_r + PHASE_W'(1);
      if (sub_r == SUB_LAST) begin
        sub_nxt = '0;
        quo_nxt = quo_r + QUO_W'(1);
      end else begin
        sub_nxt = sub_r + SUB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      sub_r   <= '0;
      quo_r   <= '0;
      shift_r <= '0;
      wait_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      quo_r   <= quo_nxt;
      shift_r <= shift_nxt;
      wait_r  <= wait_nxt;
    end
  end

  assign res.byte_done     = done;
  assign res.rx_data       = shift_nxt;
  assign res.frame_dropped = dropped;
  assign res.timed_out     = tout;

endmodule
